[src/jet_pkg.sv]
// ----------------------------------------------------------------------------
// jet_pkg
// Shared types, constants and helpers of the Julia escape-time pixel unit.
// ----------------------------------------------------------------------------
`default_nettype none

package jet_pkg;

	// Field and coordinate widths
	localparam int PIX_W      = 10;
	localparam int COORD_W    = 32;
	localparam int ZOOM_W     = 31;
	localparam int ITER_W     = 12;
	localparam int COLOR_W    = 24;
	localparam int FRAC_BITS  = 28;
	localparam int PROD_W     = 2 * COORD_W;
	localparam int SATW       = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Start point mapping: t = (p << MAP_SHIFT) / SIZE - 2.0
	localparam int      MAP_SHIFT = 30;
	localparam longint  MAP_BIAS  = 64'sd536870912;

	// Escape bound 4.0 in Q8.56
	localparam logic [PROD_W-1:0] ESC_LIMIT = 64'h0400_0000_0000_0000;

	// Restoring divider: one quotient bit per cycle over color x step bits
	localparam int DIV_STEPS = COLOR_W + ITER_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Default image size
	localparam int IMAGE_WIDTH_DEF  = 1024;
	localparam int IMAGE_HEIGHT_DEF = 1024;

	// Saturation bounds of Q4.28
	localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;

	// Register reset values
	localparam logic [ZOOM_W-1:0]         ZOOM_RST      = 31'h1000_0000;
	localparam logic signed [COORD_W-1:0] OFFSET_RST    = 32'sd0;
	localparam logic [ITER_W-1:0]         MAX_ITER_RST  = 12'd256;
	localparam logic signed [COORD_W-1:0] CONST_RE_RST  = -32'sd214748365;
	localparam logic signed [COORD_W-1:0] CONST_IM_RST  = 32'sd41875931;
	localparam logic [COLOR_W-1:0]        NEAR_RST      = 24'hFF_FFFF;
	localparam logic [COLOR_W-1:0]        FAR_RST       = 24'h00_0000;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ZOOM       = 3'd0,
		REG_OFFSET_RE  = 3'd1,
		REG_OFFSET_IM  = 3'd2,
		REG_MAX_ITER   = 3'd3,
		REG_CONST_RE   = 3'd4,
		REG_CONST_IM   = 3'd5,
		REG_NEAR_COLOR = 3'd6,
		REG_FAR_COLOR  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [ZOOM_W-1:0]         zoom;
		logic signed [COORD_W-1:0] offset_re;
		logic signed [COORD_W-1:0] offset_im;
		logic [ITER_W-1:0]         max_iterations;
		logic signed [COORD_W-1:0] const_re;
		logic signed [COORD_W-1:0] const_im;
		logic [COLOR_W-1:0]        near_color;
		logic [COLOR_W-1:0]        far_color;
	} cfg_t;

	// Channel payloads
	typedef struct packed {
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
	} pix_t;

	typedef struct packed {
		logic [COLOR_W-1:0] pixel_color;
		logic [ITER_W-1:0]  escape_step;
		logic               escaped;
	} res_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_MAP,
		S_INIT,
		S_MUL,
		S_ITER,
		S_CMUL,
		S_DIV,
		S_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic take;
		logic map;
		logic init;
		logic mul;
		logic iter;
		logic cmul;
		logic div;
		logic load_out;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic hit;
		logic at_limit;
	} sts_t;

	// Clamp a wide signed value to Q4.28
	function automatic logic signed [COORD_W-1:0] sat_q(input logic signed [SATW-1:0] v);
		logic signed [SATW-1:0] hi;
		logic signed [SATW-1:0] lo;
		hi = SATW'(Q_MAX);
		lo = SATW'(Q_MIN);
		if (v > hi) begin
			return Q_MAX;
		end else if (v < lo) begin
			return Q_MIN;
		end
		return $signed(v[COORD_W-1:0]);
	endfunction

endpackage

`default_nettype wire

[src/jet_stream_if.sv]
// ----------------------------------------------------------------------------
// jet_stream_if
// Valid/ready stream channel with a typed payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface jet_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/jet_cfg.sv]
// ----------------------------------------------------------------------------
// jet_cfg
// Configuration register file: view, iteration limit, constant and colors.
// ----------------------------------------------------------------------------
`default_nettype none

module jet_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [jet_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [jet_pkg::CFG_DATA_W-1:0]  wr_data,
	output jet_pkg::cfg_t                        cfg
);

	jet_pkg::cfg_t cfg_q;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zoom           <= jet_pkg::ZOOM_RST;
			cfg_q.offset_re      <= jet_pkg::OFFSET_RST;
			cfg_q.offset_im      <= jet_pkg::OFFSET_RST;
			cfg_q.max_iterations <= jet_pkg::MAX_ITER_RST;
			cfg_q.const_re       <= jet_pkg::CONST_RE_RST;
			cfg_q.const_im       <= jet_pkg::CONST_IM_RST;
			cfg_q.near_color     <= jet_pkg::NEAR_RST;
			cfg_q.far_color      <= jet_pkg::FAR_RST;
		end else if (wr_en) begin
			unique case (jet_pkg::cfg_reg_t'(wr_index))
				jet_pkg::REG_ZOOM:       cfg_q.zoom <= wr_data[jet_pkg::ZOOM_W-1:0];
				jet_pkg::REG_OFFSET_RE:  cfg_q.offset_re <= $signed(wr_data);
				jet_pkg::REG_OFFSET_IM:  cfg_q.offset_im <= $signed(wr_data);
				jet_pkg::REG_MAX_ITER:   cfg_q.max_iterations <= wr_data[jet_pkg::ITER_W-1:0];
				jet_pkg::REG_CONST_RE:   cfg_q.const_re <= $signed(wr_data);
				jet_pkg::REG_CONST_IM:   cfg_q.const_im <= $signed(wr_data);
				jet_pkg::REG_NEAR_COLOR: cfg_q.near_color <= wr_data[jet_pkg::COLOR_W-1:0];
				jet_pkg::REG_FAR_COLOR:  cfg_q.far_color <= wr_data[jet_pkg::COLOR_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[src/jet_dp.sv]
// ----------------------------------------------------------------------------
// jet_dp
// Datapath: start point mapping, complex square-and-add with escape test,
// color ramp multiply and a restoring divider, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module jet_dp #(
	parameter int IMAGE_WIDTH  = jet_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = jet_pkg::IMAGE_HEIGHT_DEF
) (
	input  wire logic         clk,
	input  wire jet_pkg::cfg_t cfg,
	input  wire jet_pkg::cmd_t cmd,
	input  wire jet_pkg::pix_t pix,
	output jet_pkg::sts_t      sts,
	output jet_pkg::res_t      res
);

	localparam int SHX = jet_pkg::MAP_SHIFT - $clog2(IMAGE_WIDTH);
	localparam int SHY = jet_pkg::MAP_SHIFT - $clog2(IMAGE_HEIGHT);
	localparam int TWX = SHX + jet_pkg::PIX_W + 2;
	localparam int TWY = SHY + jet_pkg::PIX_W + 2;
	localparam int PWX = TWX + jet_pkg::COORD_W;
	localparam int PWY = TWY + jet_pkg::COORD_W;
	localparam int CW  = jet_pkg::COLOR_W;
	localparam int IW  = jet_pkg::ITER_W;
	localparam int DS  = jet_pkg::DIV_STEPS;
	localparam int SW  = jet_pkg::SATW;
	localparam int PW  = jet_pkg::PROD_W;
	localparam int FB  = jet_pkg::FRAC_BITS;

	localparam logic signed [TWX-1:0] BIAS_X = TWX'(jet_pkg::MAP_BIAS);
	localparam logic signed [TWY-1:0] BIAS_Y = TWY'(jet_pkg::MAP_BIAS);

	// Registers
	logic [jet_pkg::PIX_W-1:0]         px_q, py_q;
	logic signed [PWX-1:0]             mx_q;
	logic signed [PWY-1:0]             my_q;
	logic signed [jet_pkg::COORD_W-1:0] zr_q, zi_q;
	logic signed [PW-1:0]              zr2_q, zi2_q, zri_q;
	logic [IW-1:0]                     step_q, rstep_q;
	logic                              esc_q, neg_q;
	logic [DS-1:0]                     quo_q;
	logic [IW-1:0]                     rem_q;
	jet_pkg::res_t                     res_q;

	// Combinational terms
	logic signed [TWX-1:0]             tx;
	logic signed [TWY-1:0]             ty;
	logic signed [jet_pkg::COORD_W-1:0] zoom_s;
	logic signed [PWX-1:0]             mx_sh;
	logic signed [PWY-1:0]             my_sh;
	logic signed [SW-1:0]              sx, sy;
	logic signed [PW-1:0]              dre, dre_sh, zri_sh;
	logic signed [SW-1:0]              nre, nim;
	logic [PW-1:0]                     mag;
	logic signed [CW:0]                diff;
	logic signed [CW:0]                diff_abs;
	logic [IW:0]                       rem_sh, rem_sub;
	logic                              ge;
	logic [CW-1:0]                     color;

	// Map pixel indexes to offsets from -2.0
	always_comb begin
		tx     = TWX'($signed({1'b0, px_q, {SHX{1'b0}}})) - BIAS_X;
		ty     = TWY'($signed({1'b0, py_q, {SHY{1'b0}}})) - BIAS_Y;
		zoom_s = $signed({1'b0, cfg.zoom});
		mx_sh  = mx_q >>> FB;
		my_sh  = my_q >>> FB;
		sx     = SW'(mx_sh) + SW'(cfg.offset_re);
		sy     = SW'(my_sh) + SW'(cfg.offset_im);
	end

	// Square-and-add step and escape magnitude
	always_comb begin
		dre    = zr2_q - zi2_q;
		dre_sh = dre >>> FB;
		zri_sh = zri_q >>> (FB - 1);
		nre    = SW'(dre_sh) + SW'(cfg.const_re);
		nim    = SW'(zri_sh) + SW'(cfg.const_im);
		mag    = $unsigned(zr2_q) + $unsigned(zi2_q);
		sts.hit      = (step_q != '0) && (mag > jet_pkg::ESC_LIMIT);
		sts.at_limit = (step_q == cfg.max_iterations);
	end

	// Color ramp difference and one divider step
	always_comb begin
		diff     = $signed({1'b0, cfg.far_color}) - $signed({1'b0, cfg.near_color});
		diff_abs = diff[CW] ? -diff : diff;
		rem_sh   = {rem_q, quo_q[DS-1]};
		ge       = (rem_sh >= {1'b0, cfg.max_iterations});
		rem_sub  = rem_sh - {1'b0, cfg.max_iterations};
		if (!esc_q) begin
			color = cfg.far_color;
		end else if (neg_q) begin
			color = cfg.near_color - quo_q[CW-1:0];
		end else begin
			color = cfg.near_color + quo_q[CW-1:0];
		end
	end

	// Capture the pixel and form the mapping products
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			px_q <= pix.pixel_x;
			py_q <= pix.pixel_y;
		end
		if (cmd.map) begin
			mx_q <= PWX'(tx) * PWX'(zoom_s);
			my_q <= PWY'(ty) * PWY'(zoom_s);
		end
	end

	// Hold z, its products and the step count
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			zr_q   <= jet_pkg::sat_q(sx);
			zi_q   <= jet_pkg::sat_q(sy);
			step_q <= '0;
			esc_q  <= 1'b0;
		end
		if (cmd.mul) begin
			zr2_q <= PW'(zr_q) * PW'(zr_q);
			zi2_q <= PW'(zi_q) * PW'(zi_q);
			zri_q <= PW'(zr_q) * PW'(zi_q);
		end
		if (cmd.iter) begin
			if (sts.hit) begin
				esc_q   <= 1'b1;
				rstep_q <= step_q - IW'(1);
			end else if (sts.at_limit) begin
				esc_q   <= 1'b0;
				rstep_q <= step_q;
			end else begin
				zr_q   <= jet_pkg::sat_q(nre);
				zi_q   <= jet_pkg::sat_q(nim);
				step_q <= step_q + IW'(1);
			end
		end
	end

	// Scale the color difference, then divide by the limit one bit a cycle
	always_ff @(posedge clk) begin
		if (cmd.cmul) begin
			quo_q <= {{IW{1'b0}}, diff_abs[CW-1:0]} * {{CW{1'b0}}, rstep_q};
			rem_q <= '0;
			neg_q <= diff[CW];
		end
		if (cmd.div) begin
			rem_q <= ge ? rem_sub[IW-1:0] : rem_sh[IW-1:0];
			quo_q <= {quo_q[DS-2:0], ge};
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_q.pixel_color <= color;
			res_q.escape_step <= rstep_q;
			res_q.escaped     <= esc_q;
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

[src/jet_ctrl.sv]
// ----------------------------------------------------------------------------
// jet_ctrl
// Controller: sequences mapping, iteration, color division and result
// handoff; owns the divider count and the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module jet_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire jet_pkg::sts_t sts,
	output jet_pkg::cmd_t      cmd
);

	localparam logic [jet_pkg::DIV_CNT_W-1:0] DIV_LAST =
		jet_pkg::DIV_CNT_W'(jet_pkg::DIV_STEPS - 1);

	jet_pkg::state_t                 state_q, state_d;
	logic [jet_pkg::DIV_CNT_W-1:0]   div_cnt_q;
	logic                            out_valid_q;
	logic                            out_free;

	assign out_free = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			jet_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = jet_pkg::S_MAP;
				end
			end
			jet_pkg::S_MAP:  state_d = jet_pkg::S_INIT;
			jet_pkg::S_INIT: state_d = jet_pkg::S_MUL;
			jet_pkg::S_MUL:  state_d = jet_pkg::S_ITER;
			jet_pkg::S_ITER: begin
				if (sts.hit) begin
					state_d = jet_pkg::S_CMUL;
				end else if (sts.at_limit) begin
					state_d = jet_pkg::S_DONE;
				end else begin
					state_d = jet_pkg::S_MUL;
				end
			end
			jet_pkg::S_CMUL: state_d = jet_pkg::S_DIV;
			jet_pkg::S_DIV: begin
				if (div_cnt_q == DIV_LAST) begin
					state_d = jet_pkg::S_DONE;
				end
			end
			jet_pkg::S_DONE: begin
				if (out_free) begin
					state_d = jet_pkg::S_IDLE;
				end
			end
		endcase
	end

	// Commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			jet_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			jet_pkg::S_MAP:  cmd.map  = 1'b1;
			jet_pkg::S_INIT: cmd.init = 1'b1;
			jet_pkg::S_MUL:  cmd.mul  = 1'b1;
			jet_pkg::S_ITER: cmd.iter = 1'b1;
			jet_pkg::S_CMUL: cmd.cmul = 1'b1;
			jet_pkg::S_DIV:  cmd.div  = 1'b1;
			jet_pkg::S_DONE: cmd.load_out = out_free;
		endcase
	end

	// Advance state, divider count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= jet_pkg::S_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.cmul) begin
				div_cnt_q <= '0;
			end else if (cmd.div) begin
				div_cnt_q <= div_cnt_q + jet_pkg::DIV_CNT_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[src/julia_escape_time_pixel_unit.sv]
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_unit
// Julia set escape-time evaluator for one pixel at a time.
// ----------------------------------------------------------------------------
// Usage:
//   pixel  : valid/ready sink of {pixel_x, pixel_y}; one transfer per pixel.
//   result : valid/ready source of {pixel_color, escape_step, escaped}.
//   wr_en / wr_index / wr_data write the eight view, limit, constant and
//   color registers; write them only while no pixel is in flight.
// An escaping pixel also passes through the color multiply and divide;
// a pixel that reaches the limit goes straight to the result register.
// Each step goes through the complex multiplier set (square and cross
// products registered, then add and saturate); the color ramp
// uses a one-bit-per-cycle restoring divider.
// One pixel is processed at a time; pixel.ready is high only while idle.
// A finished result sits in the output register, and the next pixel is
// accepted while it waits. If result is stalled when the next pixel
// finishes, the unit holds that pixel until the register frees.
// Reset clears the controller and restores the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module julia_escape_time_pixel_unit #(
	parameter int IMAGE_WIDTH  = jet_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = jet_pkg::IMAGE_HEIGHT_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [jet_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [jet_pkg::CFG_DATA_W-1:0] wr_data,
	jet_stream_if.sink                          pixel,
	jet_stream_if.source                        result
);

	jet_pkg::cfg_t cfg;
	jet_pkg::cmd_t cmd;
	jet_pkg::sts_t sts;
	jet_pkg::res_t res;
	jet_pkg::pix_t pix;
	logic          in_ready;
	logic          out_valid;

	assign pix = pixel.data;

	jet_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	jet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	jet_dp #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT)
	) u_dp (
		.clk (clk),
		.cfg (cfg),
		.cmd (cmd),
		.pix (pix),
		.sts (sts),
		.res (res)
	);

	// Drive the channel handshakes and payload
	assign pixel.ready  = in_ready;
	assign result.valid = out_valid;
	assign result.data  = res;

endmodule

`default_nettype wire

[src/jet_checker.sv]
// ----------------------------------------------------------------------------
// jet_checker
// Port-level checks of the pixel unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jet_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_ready,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire jet_pkg::res_t out_data
);

	// A stalled result holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// One pixel at a time: ready drops after a transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("pixel accepted while busy");

	// An idle unit stays ready until a pixel arrives
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !in_valid |=> in_ready)
		else $error("ready dropped without a transfer");

	// No result can appear right after a pixel transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind julia_escape_time_pixel_unit jet_checker u_jet_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel.valid),
	.in_ready  (pixel.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);

`default_nettype wire

[tb/julia_escape_time_pixel_unit_test.sv]
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_unit_test
// Self-checking bench for the Julia escape-time pixel unit. Pixels are fed
// through the valid/ready input channel with random gaps. Each accepted
// pixel is scored by a fixed-point model of the start point mapping, the
// z*z + c iteration and the color ramp. Results are compared field by field
// in order, while the result side stalls at random and twice holds off long
// enough to back the unit up. Directed views cover the edges of the image,
// a zero iteration limit, saturated coordinates, the full iteration limit
// and a slow escape. Random views follow, with most limits small.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import jet_pkg::*;

	localparam longint      IMAGE_W        = 1024;
	localparam longint      IMAGE_H        = 1024;
	localparam logic [63:0] ESCAPE_BOUND   = 64'h0400_0000_0000_0000;
	localparam int          RANDOM_ITEMS   = 1750;
	localparam int          OFFSET_SPAN    = 32'h0800_0000;
	localparam int          CONST_SPAN     = 214748364;
	localparam int          HOLD_CYCLES    = 1200;
	localparam int          WATCHDOG_LIMIT = 30000;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  wr_en     = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index  = '0;
	logic [CFG_DATA_W-1:0] wr_data   = '0;
	logic                  pix_valid = 1'b0;
	pix_t                  pix_data  = '0;
	logic                  res_ready = 1'b0;

	jet_stream_if #(.T(pix_t)) pixel_ch ();
	jet_stream_if #(.T(res_t)) result_ch ();

	assign pixel_ch.valid  = pix_valid;
	assign pixel_ch.data   = pix_data;
	assign result_ch.ready = res_ready;

	julia_escape_time_pixel_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.pixel    (pixel_ch),
		.result   (result_ch)
	);

	// Register mirror, starts at the reset values
	cfg_t view = '{
		zoom:           ZOOM_RST,
		offset_re:      OFFSET_RST,
		offset_im:      OFFSET_RST,
		max_iterations: MAX_ITER_RST,
		const_re:       CONST_RE_RST,
		const_im:       CONST_IM_RST,
		near_color:     NEAR_RST,
		far_color:      FAR_RST
	};

	pix_t pixel_backlog[$];
	res_t predicted_results[$];
	res_t want;
	res_t got;
	logic idle_on = 1'b1;
	int   gap_left;
	int   stall_left;
	int   ready_wait;
	int   hold_left;
	int   holds_done;
	int   received;
	int   quiet_cycles;
	int   mismatches;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Clamp to the signed Q4.28 range
	function automatic longint clamp_q(input longint v);
		if (v > longint'(Q_MAX)) return longint'(Q_MAX);
		if (v < longint'(Q_MIN)) return longint'(Q_MIN);
		return v;
	endfunction

	// Map a pixel index to a start coordinate: (-2 + 4p/size) * zoom + offset
	function automatic longint start_point(input logic [PIX_W-1:0] p, input longint size,
			input longint scale, input longint off);
		longint t;
		t = (longint'({54'd0, p}) <<< 30) / size - (longint'(2) <<< FRAC_BITS);
		return clamp_q(((t * scale) >>> FRAC_BITS) + off);
	endfunction

	// Escape step, flag and ramp color of one pixel under a given view
	function automatic res_t evaluate_pixel(input pix_t px, input cfg_t v);
		longint      zr;
		longint      zi;
		longint      nr;
		longint      ni;
		longint      span;
		logic [63:0] mag;
		int          n;
		logic        hit;
		res_t        r;
		zr = start_point(px.pixel_x, IMAGE_W, longint'({33'd0, v.zoom}),
			longint'($signed(v.offset_re)));
		zi = start_point(px.pixel_y, IMAGE_H, longint'({33'd0, v.zoom}),
			longint'($signed(v.offset_im)));
		hit = 1'b0;
		for (n = 0; n < int'(v.max_iterations); n++) begin
			nr = clamp_q(((zr * zr - zi * zi) >>> FRAC_BITS) + longint'($signed(v.const_re)));
			ni = clamp_q(((zr * zi) >>> (FRAC_BITS - 1)) + longint'($signed(v.const_im)));
			zr = nr;
			zi = ni;
			mag = 64'(zr * zr) + 64'(zi * zi);
			if (mag > ESCAPE_BOUND) begin
				hit = 1'b1;
				break;
			end
		end
		r.escaped = hit;
		r.escape_step = n[ITER_W-1:0];
		r.pixel_color = v.far_color;
		if (hit) begin
			span = longint'(v.far_color) - longint'(v.near_color);
			r.pixel_color = COLOR_W'(longint'(v.near_color)
				+ span * n / longint'(v.max_iterations));
		end
		return r;
	endfunction

	// Random coordinate: mostly within +/- span, sometimes at the range ends
	function automatic logic signed [COORD_W-1:0] pick_coord(input int unsigned span);
		case ($urandom_range(0, 15))
			0: return Q_MIN;
			1: return Q_MAX;
			2: return $urandom;
			default: return $urandom_range(0, 2 * span) - span;
		endcase
	endfunction

	function automatic logic [COLOR_W-1:0] pick_color();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return COLOR_W'($urandom);
		endcase
	endfunction

	task automatic queue_pixel(input int x, input int y);
		pixel_backlog.push_back('{pixel_x: PIX_W'(x), pixel_y: PIX_W'(y)});
	endtask

	// Wait until every pixel has been sent and every result has come back
	task automatic drain();
		do @(negedge clk);
		while (pixel_backlog.size() != 0 || pix_valid || predicted_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// Program a whole view once the unit is idle
	task automatic load_view(input cfg_t c);
		drain();
		write_reg(REG_ZOOM, {1'b0, c.zoom});
		write_reg(REG_OFFSET_RE, c.offset_re);
		write_reg(REG_OFFSET_IM, c.offset_im);
		write_reg(REG_MAX_ITER, CFG_DATA_W'(c.max_iterations));
		write_reg(REG_CONST_RE, c.const_re);
		write_reg(REG_CONST_IM, c.const_im);
		write_reg(REG_NEAR_COLOR, CFG_DATA_W'(c.near_color));
		write_reg(REG_FAR_COLOR, CFG_DATA_W'(c.far_color));
		view = c;
	endtask

	// Pixel driver: offer backlog items, with random idle gaps between transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
			pix_data <= '0;
			gap_left <= 0;
		end else if (!pix_valid || pixel_ch.ready) begin
			if (gap_left != 0) begin
				pix_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pixel_backlog.size() != 0) begin
				pix_data <= pixel_backlog.pop_front();
				pix_valid <= 1'b1;
				gap_left <= idle_on ? $urandom_range(0, 17) : 0;
			end else begin
				pix_valid <= 1'b0;
			end
		end
	end

	// Result receiver: stall after transfers, hold off long twice
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			holds_done <= 0;
			received <= 0;
		end else begin
			if (result_ch.valid && res_ready) begin
				received <= received + 1;
			end
			if (hold_left != 0) begin
				res_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (result_ch.valid && res_ready) begin
				if (holds_done < 2 && received >= 60 + holds_done * 800
						&& pixel_backlog.size() > 4) begin
					res_ready <= 1'b0;
					hold_left <= HOLD_CYCLES;
					holds_done <= holds_done + 1;
				end else begin
					ready_wait = idle_on ? $urandom_range(0, 17) : 0;
					res_ready <= (ready_wait == 0);
					stall_left <= ready_wait;
				end
			end else if (!res_ready) begin
				if (stall_left <= 1) begin
					res_ready <= 1'b1;
				end else begin
					stall_left <= stall_left - 1;
				end
			end
		end
	end

	// Score input transfers, check output transfers, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				got = result_ch.data;
				if (predicted_results.size() == 0) begin
					$error("result with no pixel pending: color %06h step %0d escaped %0b",
						got.pixel_color, got.escape_step, got.escaped);
					mismatches++;
				end else begin
					want = predicted_results.pop_front();
					if (got.pixel_color !== want.pixel_color) begin
						$error("pixel_color: expected %06h, got %06h",
							want.pixel_color, got.pixel_color);
						mismatches++;
					end
					if (got.escape_step !== want.escape_step) begin
						$error("escape_step: expected %0d, got %0d",
							want.escape_step, got.escape_step);
						mismatches++;
					end
					if (got.escaped !== want.escaped) begin
						$error("escaped: expected %0b, got %0b", want.escaped, got.escaped);
						mismatches++;
					end
				end
			end
			if (pixel_ch.valid && pixel_ch.ready) begin
				predicted_results.push_back(evaluate_pixel(pixel_ch.data, view));
			end
		end
		if ((pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		cfg_t c;
		int   batch;
		int   queued;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset view: corners, center and a few interior points
		queue_pixel(0, 0);
		queue_pixel(1023, 1023);
		queue_pixel(0, 1023);
		queue_pixel(1023, 0);
		queue_pixel(512, 512);
		queue_pixel(600, 480);
		queue_pixel(300, 700);

		// Zero iteration limit: no step, far color
		c = view;
		c.max_iterations = '0;
		load_view(c);
		queue_pixel(512, 512);
		queue_pixel(1023, 0);

		// Saturated start points under the largest zoom and offsets
		c.zoom = '1;
		c.offset_re = Q_MAX;
		c.offset_im = Q_MIN;
		c.max_iterations = '1;
		c.near_color = 24'h12_3456;
		c.far_color = 24'hFE_DCBA;
		load_view(c);
		queue_pixel(0, 0);
		queue_pixel(1023, 1023);
		queue_pixel(512, 512);
		queue_pixel(0, 1023);

		// Fixed point at the origin: runs the full limit
		c.zoom = '0;
		c.offset_re = '0;
		c.offset_im = '0;
		c.const_re = '0;
		c.const_im = '0;
		c.near_color = '0;
		c.far_color = '1;
		load_view(c);
		queue_pixel(1023, 1023);
		queue_pixel(0, 0);

		// Extreme constant with a single step
		c.zoom = ZOOM_RST;
		c.const_re = Q_MIN;
		c.const_im = Q_MAX;
		c.max_iterations = 12'd1;
		c.near_color = '1;
		c.far_color = '0;
		load_view(c);
		queue_pixel(5, 1000);
		queue_pixel(1018, 3);

		// Constant just past the cusp: escapes after many steps
		c.zoom = '0;
		c.const_re = 32'sd67109132;
		c.const_im = '0;
		c.max_iterations = '1;
		c.near_color = 24'h00_FF00;
		c.far_color = 24'hFF_0000;
		load_view(c);
		queue_pixel(77, 901);

		// Random views, mostly small limits
		queued = 0;
		while (queued < RANDOM_ITEMS) begin
			case ($urandom_range(0, 7))
				0: c.zoom = '0;
				1: c.zoom = '1;
				2: c.zoom = ZOOM_W'($urandom);
				default: c.zoom = ZOOM_W'($urandom_range(32'h0200_0000, 32'h2000_0000));
			endcase
			c.offset_re = pick_coord(OFFSET_SPAN);
			c.offset_im = pick_coord(OFFSET_SPAN);
			c.const_re = pick_coord(CONST_SPAN);
			c.const_im = pick_coord(CONST_SPAN);
			case ($urandom_range(0, 39))
				0: c.max_iterations = '0;
				1: c.max_iterations = '1;
				2, 3, 4, 5: c.max_iterations = ITER_W'($urandom_range(49, 320));
				default: c.max_iterations = ITER_W'($urandom_range(1, 48));
			endcase
			c.near_color = pick_color();
			c.far_color = pick_color();
			load_view(c);
			idle_on = ($urandom_range(0, 3) != 0);
			batch = (c.max_iterations > 320) ? $urandom_range(3, 6) : $urandom_range(15, 70);
			repeat (batch) queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
			queued += batch;
		end

		drain();
		repeat (16) @(posedge clk);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
